// File: rtl/core/bmm_pkg.sv
`timescale 1ns / 1ps

package bmm_pkg;

  // Default sizes of the tile
  localparam int DEF_MAX_ROWS  = 8;
  localparam int DEF_MAX_COLS  = 8;
  localparam int DEF_MAX_DEPTH = 64;
  localparam int DEF_MAX_BATCH = 4096;

  // Fixed field widths
  localparam int OP_W       = 2;
  localparam int FP_W       = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int ROW_W      = 3;
  localparam int COL_W      = 3;
  localparam int BATCH_W    = 12;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD_LHS = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_RHS = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DEPTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_TOTAL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LHS_COL_MAJOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RHS_COL_MAJOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COL_MAJOR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCHED_MODE  = 3'd7;

  // Binary32 constants
  localparam logic [FP_W-1:0] FP_QNAN = 32'h7FC0_0000;

  // Rounder: value = sig * 2^exp
  localparam int RND_SW = 48;
  localparam int RND_XW = 12;
  localparam int RND_LAT = 3;
  localparam logic signed [RND_XW-1:0] RND_FRAC    = 12'sd23;
  localparam logic signed [RND_XW-1:0] RND_LSB_MIN = -12'sd149;
  localparam logic signed [RND_XW-1:0] RND_BIAS    = 12'sd150;
  localparam logic signed [RND_XW-1:0] RND_EXP_MAX = 12'sd255;
  localparam logic signed [RND_XW-1:0] RND_SH_MAX  = 12'sd49;
  localparam logic signed [RND_XW-1:0] RND_MUL_OFS = 12'sd300;
  localparam logic signed [RND_XW-1:0] RND_ADD_OFS = 12'sd153;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELEM_START,
    ST_READ,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_ADD_GO,
    ST_ADD_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic item_take;
    logic acc_clr;
    logic mem_read;
    logic mul_start;
    logic add_start;
    logic depth_step;
    logic out_load;
    logic elem_step;
    logic batch_end;
  } ctrl_cmd_t;

  typedef struct packed {
    logic depth_zero;
    logic depth_last;
    logic elem_last;
    logic mul_done;
    logic add_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: rtl/core/batched_matrix_multiply.sv
`timescale 1ns / 1ps
// Batched binary32 matrix multiply on one tile of up to MAX_ROWS x MAX_COLS.
// Input channel (in_valid/in_ready): each transfer carries an operation.
//   Load left / load right: write in_element_value at the next slot of that
//   store, in the configured storage order. Loads past the matrix size, and
//   loads of a non-batched operand after batch 0, are dropped.
//   Compute: emits rows*cols sums on the output channel in output order.
// Output channel (out_valid/out_ready): one sum per transfer with its row,
//   column, batch number and a last flag on the final element of the batch.
// Each multiply-add steps through a store read, a multiply and an add, each
//   started by its own issue step; the sequencer waits for each unit to finish.
// One item is processed at a time; in_ready is high only while idle.
// An output register parts the channels: a stalled receiver holds the current
//   result and halts the next element at its emit step.
// Reset (rst_n low, synchronous) restores the register defaults and clears the
//   load pointers and batch counter; store contents stay undefined.
// Configuration writes (cfg_write_en) take effect at once; write only while idle.
module batched_matrix_multiply #(
  parameter int MAX_ROWS  = bmm_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = bmm_pkg::DEF_MAX_COLS,
  parameter int MAX_DEPTH = bmm_pkg::DEF_MAX_DEPTH,
  parameter int MAX_BATCH = bmm_pkg::DEF_MAX_BATCH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_en,
  input  logic [bmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bmm_pkg::OP_W-1:0]       in_operation,
  input  logic [bmm_pkg::FP_W-1:0]       in_element_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bmm_pkg::FP_W-1:0]       out_result_value,
  output logic [bmm_pkg::ROW_W-1:0]      out_row,
  output logic [bmm_pkg::COL_W-1:0]      out_col,
  output logic [bmm_pkg::BATCH_W-1:0]    out_batch_index,
  output logic                           out_last_of_batch
);
  import bmm_pkg::*;

  // Commands from the sequencer, status back from the datapath
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  bmm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Stores, address generation, float units and the output register
  bmm_dpath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_DEPTH (MAX_DEPTH),
    .MAX_BATCH (MAX_BATCH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_operation      (in_operation),
    .in_element_value  (in_element_value),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_value  (out_result_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_batch_index   (out_batch_index),
    .out_last_of_batch (out_last_of_batch)
  );

endmodule

// File: rtl/core/bmm_fround.sv
`timescale 1ns / 1ps

module bmm_fround (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_sign,
  input  logic                                in_special,
  input  logic [bmm_pkg::FP_W-1:0]            in_special_bits,
  input  logic [bmm_pkg::RND_SW-1:0]          in_sig,
  input  logic signed [bmm_pkg::RND_XW-1:0]   in_exp,
  output logic                                out_valid,
  output logic [bmm_pkg::FP_W-1:0]            out_result
);
  import bmm_pkg::*;

  localparam int SHW = 7;
  localparam int GW  = RND_SW + 2;

  logic                     v0_r, v1_r, v2_r;
  logic                     sign0_r, sign1_r;
  logic                     spec0_r, spec1_r;
  logic [FP_W-1:0]          specb0_r, specb1_r;
  logic [RND_SW-1:0]        sig0_r, sig1_r;
  logic signed [RND_XW-1:0] exp0_r, lsb1_r;
  logic signed [SHW-1:0]    sh1_r;
  logic [FP_W-1:0]          res2_r;

  logic [5:0]               msb;
  logic signed [RND_XW-1:0] lsb_raw, lsb_clip, sh_full;
  logic signed [SHW-1:0]    sh_nxt;

  logic [RND_SW+GW-1:0]     wide;
  logic [RND_SW-1:0]        left;
  logic [23:0]              mant, mf;
  logic                     guard, sticky, inc;
  logic [24:0]              m2;
  logic signed [RND_XW-1:0] lsb_fin, bexp;
  logic [FP_W-1:0]          res_nxt;

  // Stage one: find the leading one and the weight of the kept LSB
  always_comb begin
    msb = '0;
    for (int k = 0; k < RND_SW; k++) begin
      if (sig0_r[k]) msb = 6'(k);
    end
    lsb_raw  = exp0_r + $signed({6'd0, msb}) - RND_FRAC;
    lsb_clip = (lsb_raw < RND_LSB_MIN) ? RND_LSB_MIN : lsb_raw;
    sh_full  = lsb_clip - exp0_r;
    sh_nxt   = (sh_full > RND_SH_MAX) ? SHW'(RND_SH_MAX) : SHW'(sh_full);
  end

  // Stage two: align, round to nearest even, pack
  always_comb begin
    wide   = '0;
    left   = '0;
    mant   = '0;
    guard  = 1'b0;
    sticky = 1'b0;
    if (sh1_r < 0) begin
      left = sig1_r << 6'(-sh1_r);
      mant = left[23:0];
    end else begin
      wide   = {sig1_r, GW'(0)} >> 6'(sh1_r);
      mant   = wide[GW+23:GW];
      guard  = wide[GW-1];
      sticky = |wide[GW-2:0];
    end
    inc     = guard & (sticky | mant[0]);
    m2      = {1'b0, mant} + 25'(inc);
    lsb_fin = lsb1_r + $signed({11'd0, m2[24]});
    mf      = m2[24] ? m2[24:1] : m2[23:0];
    bexp    = lsb_fin + RND_BIAS;
    if (spec1_r) begin
      res_nxt = specb1_r;
    end else if (!mf[23]) begin
      res_nxt = {sign1_r, 8'd0, mf[22:0]};
    end else if (bexp >= RND_EXP_MAX) begin
      res_nxt = {sign1_r, 8'hFF, 23'd0};
    end else begin
      res_nxt = {sign1_r, bexp[7:0], mf[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sign0_r  <= in_sign;
    spec0_r  <= in_special;
    specb0_r <= in_special_bits;
    sig0_r   <= in_sig;
    exp0_r   <= in_exp;
    sign1_r  <= sign0_r;
    spec1_r  <= spec0_r;
    specb1_r <= specb0_r;
    sig1_r   <= sig0_r;
    lsb1_r   <= lsb_clip;
    sh1_r    <= sh_nxt;
    res2_r   <= res_nxt;
  end

  assign out_valid  = v2_r;
  assign out_result = res2_r;

  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> ##3 out_valid)
    else $error("rounder result not delivered after three cycles");

endmodule

// File: rtl/core/bmm_fmul.sv
`timescale 1ns / 1ps

module bmm_fmul (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [bmm_pkg::FP_W-1:0] op_a,
  input  logic [bmm_pkg::FP_W-1:0] op_b,
  output logic                     done,
  output logic [bmm_pkg::FP_W-1:0] result
);
  import bmm_pkg::*;

  logic [7:0]               ea, eb, eea, eeb;
  logic [23:0]              ma, mb;
  logic                     a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic                     sign, is_nan, is_inf, special;
  logic [FP_W-1:0]          spec_bits;
  logic [RND_SW-1:0]        prod;
  logic signed [RND_XW-1:0] pexp;

  always_comb begin
    ea     = op_a[30:23];
    eb     = op_b[30:23];
    a_nan  = (&ea) & (|op_a[22:0]);
    b_nan  = (&eb) & (|op_b[22:0]);
    a_inf  = (&ea) & ~(|op_a[22:0]);
    b_inf  = (&eb) & ~(|op_b[22:0]);
    a_zero = ~(|op_a[30:0]);
    b_zero = ~(|op_b[30:0]);
    sign   = op_a[31] ^ op_b[31];
    is_nan = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
    is_inf = a_inf | b_inf;
    special = a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;
    if (is_nan) begin
      spec_bits = FP_QNAN;
    end else if (is_inf) begin
      spec_bits = {sign, 8'hFF, 23'd0};
    end else begin
      spec_bits = {sign, 31'd0};
    end
    ma   = {|ea, op_a[22:0]};
    mb   = {|eb, op_b[22:0]};
    eea  = (|ea) ? ea : 8'd1;
    eeb  = (|eb) ? eb : 8'd1;
    prod = ma * mb;
    pexp = $signed({4'd0, eea}) + $signed({4'd0, eeb}) - RND_MUL_OFS;
  end

  bmm_fround u_round (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (start),
    .in_sign         (sign),
    .in_special      (special),
    .in_special_bits (spec_bits),
    .in_sig          (prod),
    .in_exp          (pexp),
    .out_valid       (done),
    .out_result      (result)
  );

endmodule

// File: rtl/core/bmm_fadd.sv
`timescale 1ns / 1ps

module bmm_fadd (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [bmm_pkg::FP_W-1:0] op_a,
  input  logic [bmm_pkg::FP_W-1:0] op_b,
  output logic                     done,
  output logic [bmm_pkg::FP_W-1:0] result
);
  import bmm_pkg::*;

  logic [FP_W-1:0]          big, sml;
  logic [7:0]               ea, eb, eeb, ees, dexp, shc;
  logic                     a_nan, b_nan, a_inf, b_inf;
  logic                     is_nan, is_inf, sum_zero, special;
  logic [FP_W-1:0]          spec_bits;
  logic [26:0]              al_a, al_b;
  logic [53:0]              wide;
  logic [27:0]              sum;
  logic signed [RND_XW-1:0] sexp;

  always_comb begin
    ea    = op_a[30:23];
    eb    = op_b[30:23];
    a_nan = (&ea) & (|op_a[22:0]);
    b_nan = (&eb) & (|op_b[22:0]);
    a_inf = (&ea) & ~(|op_a[22:0]);
    b_inf = (&eb) & ~(|op_b[22:0]);
    is_nan = a_nan | b_nan | (a_inf & b_inf & (op_a[31] ^ op_b[31]));
    is_inf = a_inf | b_inf;

    // Larger magnitude first so the difference stays nonnegative
    if (op_a[30:0] >= op_b[30:0]) begin
      big = op_a;
      sml = op_b;
    end else begin
      big = op_b;
      sml = op_a;
    end
    eeb  = (|big[30:23]) ? big[30:23] : 8'd1;
    ees  = (|sml[30:23]) ? sml[30:23] : 8'd1;
    dexp = eeb - ees;
    shc  = (dexp > 8'd27) ? 8'd27 : dexp;

    // Three extra bits, shifted-out bits fold into the sticky bit
    al_a = {|big[30:23], big[22:0], 3'd0};
    wide = {|sml[30:23], sml[22:0], 3'd0, 27'd0} >> shc;
    al_b = wide[53:27] | {26'd0, |wide[26:0]};
    sum  = (big[31] ^ sml[31]) ? ({1'b0, al_a} - {1'b0, al_b})
                               : ({1'b0, al_a} + {1'b0, al_b});
    sexp = $signed({4'd0, eeb}) - RND_ADD_OFS;

    sum_zero = ~(|sum);
    special  = is_nan | is_inf | sum_zero;
    if (is_nan) begin
      spec_bits = FP_QNAN;
    end else if (is_inf) begin
      spec_bits = {(a_inf ? op_a[31] : op_b[31]), 8'hFF, 23'd0};
    end else begin
      spec_bits = {op_a[31] & op_b[31], 31'd0};
    end
  end

  bmm_fround u_round (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (start),
    .in_sign         (big[31]),
    .in_special      (special),
    .in_special_bits (spec_bits),
    .in_sig          (RND_SW'(sum)),
    .in_exp          (sexp),
    .out_valid       (done),
    .out_result      (result)
  );

endmodule

// File: rtl/core/bmm_ctrl.sv
`timescale 1ns / 1ps

module bmm_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [bmm_pkg::OP_W-1:0] in_operation,
  output logic                     in_ready,
  input  bmm_pkg::ctrl_sts_t       sts,
  output bmm_pkg::ctrl_cmd_t       cmd
);
  import bmm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_operation == OP_COMPUTE) state_nxt = ST_ELEM_START;
      end
      ST_ELEM_START: state_nxt = sts.depth_zero ? ST_EMIT : ST_READ;
      ST_READ:       state_nxt = ST_MUL_GO;
      ST_MUL_GO:     state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (sts.mul_done) state_nxt = ST_ADD_GO;
      end
      ST_ADD_GO:     state_nxt = ST_ADD_WAIT;
      ST_ADD_WAIT: begin
        if (sts.add_done) state_nxt = sts.depth_last ? ST_EMIT : ST_READ;
      end
      ST_EMIT: begin
        if (sts.out_free) state_nxt = sts.elem_last ? ST_IDLE : ST_ELEM_START;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.item_take = in_valid;
      end
      ST_ELEM_START: cmd.acc_clr   = 1'b1;
      ST_READ:       cmd.mem_read  = 1'b1;
      ST_MUL_GO:     cmd.mul_start = 1'b1;
      ST_MUL_WAIT:   ;
      ST_ADD_GO:     cmd.add_start = 1'b1;
      ST_ADD_WAIT:   cmd.depth_step = sts.add_done;
      ST_EMIT: begin
        cmd.out_load  = sts.out_free;
        cmd.elem_step = sts.out_free & ~sts.elem_last;
        cmd.batch_end = sts.out_free & sts.elem_last;
      end
      default: ;
    endcase
  end

  a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == OP_COMPUTE) |=> state_r == ST_ELEM_START)
    else $error("compute transfer did not start an element");

endmodule

// File: rtl/core/bmm_dpath.sv
`timescale 1ns / 1ps

module bmm_dpath #(
  parameter int MAX_ROWS  = bmm_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = bmm_pkg::DEF_MAX_COLS,
  parameter int MAX_DEPTH = bmm_pkg::DEF_MAX_DEPTH,
  parameter int MAX_BATCH = bmm_pkg::DEF_MAX_BATCH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_write_en,
  input  logic [bmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [bmm_pkg::OP_W-1:0]       in_operation,
  input  logic [bmm_pkg::FP_W-1:0]       in_element_value,
  input  bmm_pkg::ctrl_cmd_t             cmd,
  output bmm_pkg::ctrl_sts_t             sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bmm_pkg::FP_W-1:0]       out_result_value,
  output logic [bmm_pkg::ROW_W-1:0]      out_row,
  output logic [bmm_pkg::COL_W-1:0]      out_col,
  output logic [bmm_pkg::BATCH_W-1:0]    out_batch_index,
  output logic                           out_last_of_batch
);
  import bmm_pkg::*;

  localparam int LSIZE = MAX_ROWS * MAX_DEPTH;
  localparam int RSIZE = MAX_DEPTH * MAX_COLS;
  localparam int LPW   = $clog2(LSIZE + 1);
  localparam int RPW   = $clog2(RSIZE + 1);
  localparam int LAW   = (LSIZE > 1) ? $clog2(LSIZE) : 1;
  localparam int RAW   = (RSIZE > 1) ? $clog2(RSIZE) : 1;
  localparam int DW    = $clog2(MAX_DEPTH + 1);
  localparam int CW    = $clog2(MAX_BATCH + 1);

  // Configuration
  logic [3:0]  row_cnt_r, col_cnt_r;
  logic [6:0]  depth_cfg_r;
  logic [12:0] btot_r;
  logic        lcm_r, rcm_r, ocm_r;
  logic [1:0]  mode_r;

  logic [3:0]    rows_eff, cols_eff, outer_n, inner_n;
  logic [DW-1:0] depth_eff;
  logic [CW-1:0] batches_eff;
  logic [LPW-1:0] lim_l, laddr_full;
  logic [RPW-1:0] lim_r, raddr_full;

  logic [FP_W-1:0] lmem [LSIZE];
  logic [FP_W-1:0] rmem [RSIZE];
  logic [FP_W-1:0] lrd_r, rrd_r;

  logic [LPW-1:0]     lptr_r;
  logic [RPW-1:0]     rptr_r;
  logic [CW-1:0]      bcnt_r;
  logic [CW:0]        bnext;
  logic [ROW_W-1:0]   i_r, j_r, r_idx, c_idx;
  logic [DW-1:0]      d_r;
  logic [FP_W-1:0]    acc_r, prod_r;
  logic               lwe, rwe, is_compute;

  logic               mul_done, add_done;
  logic [FP_W-1:0]    mul_res, add_res;

  logic               ov_r, olast_r;
  logic [FP_W-1:0]    oval_r;
  logic [ROW_W-1:0]   orow_r;
  logic [COL_W-1:0]   ocol_r;
  logic [BATCH_W-1:0] obat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= 4'd8;
      col_cnt_r   <= 4'd8;
      depth_cfg_r <= 7'd64;
      btot_r      <= 13'd1;
      lcm_r       <= 1'b0;
      rcm_r       <= 1'b0;
      ocm_r       <= 1'b0;
      mode_r      <= 2'd3;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_ROW_COUNT:     row_cnt_r   <= cfg_data[3:0];
        CFG_COL_COUNT:     col_cnt_r   <= cfg_data[3:0];
        CFG_INNER_DEPTH:   depth_cfg_r <= cfg_data[6:0];
        CFG_BATCH_TOTAL:   btot_r      <= cfg_data;
        CFG_LHS_COL_MAJOR: lcm_r       <= cfg_data[0];
        CFG_RHS_COL_MAJOR: rcm_r       <= cfg_data[0];
        CFG_OUT_COL_MAJOR: ocm_r       <= cfg_data[0];
        CFG_BATCHED_MODE:  mode_r      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Saturate registers into their working ranges
  always_comb begin
    rows_eff = (row_cnt_r == 4'd0) ? 4'd1
             : ((row_cnt_r > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : row_cnt_r);
    cols_eff = (col_cnt_r == 4'd0) ? 4'd1
             : ((col_cnt_r > 4'(MAX_COLS)) ? 4'(MAX_COLS) : col_cnt_r);
    depth_eff = (32'(depth_cfg_r) > MAX_DEPTH) ? DW'(MAX_DEPTH) : DW'(depth_cfg_r);
    batches_eff = (btot_r == 13'd0) ? CW'(1)
                : ((32'(btot_r) > MAX_BATCH) ? CW'(MAX_BATCH) : CW'(btot_r));
    outer_n = ocm_r ? cols_eff : rows_eff;
    inner_n = ocm_r ? rows_eff : cols_eff;
    r_idx   = ocm_r ? j_r : i_r;
    c_idx   = ocm_r ? i_r : j_r;
    lim_l   = LPW'(rows_eff) * LPW'(depth_eff);
    lim_r   = RPW'(cols_eff) * RPW'(depth_eff);
    laddr_full = lcm_r ? (LPW'(d_r) * LPW'(rows_eff) + LPW'(r_idx))
                       : (LPW'(r_idx) * LPW'(depth_eff) + LPW'(d_r));
    raddr_full = rcm_r ? (RPW'(c_idx) * RPW'(depth_eff) + RPW'(d_r))
                       : (RPW'(d_r) * RPW'(cols_eff) + RPW'(c_idx));
    is_compute = cmd.item_take && (in_operation == OP_COMPUTE);
    lwe = cmd.item_take && (in_operation == OP_LOAD_LHS)
          && (mode_r[0] || bcnt_r == '0) && (lptr_r < lim_l);
    rwe = cmd.item_take && (in_operation == OP_LOAD_RHS)
          && (mode_r[1] || bcnt_r == '0) && (rptr_r < lim_r);
    bnext = {1'b0, bcnt_r} + 1'b1;
  end

  // Operand stores
  always_ff @(posedge clk) begin
    if (lwe) lmem[LAW'(lptr_r)] <= in_element_value;
    if (rwe) rmem[RAW'(rptr_r)] <= in_element_value;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      lrd_r <= lmem[LAW'(laddr_full)];
      rrd_r <= rmem[RAW'(raddr_full)];
    end
  end

  // Pointers, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lptr_r <= '0;
      rptr_r <= '0;
      bcnt_r <= '0;
      i_r    <= '0;
      j_r    <= '0;
      d_r    <= '0;
    end else begin
      if (cmd.batch_end) begin
        lptr_r <= '0;
        rptr_r <= '0;
        bcnt_r <= (bnext >= {1'b0, batches_eff}) ? '0 : bnext[CW-1:0];
      end else begin
        if (lwe) lptr_r <= lptr_r + 1'b1;
        if (rwe) rptr_r <= rptr_r + 1'b1;
      end
      if (is_compute) begin
        i_r <= '0;
        j_r <= '0;
      end else if (cmd.elem_step) begin
        if (j_r == 3'(inner_n - 4'd1)) begin
          j_r <= '0;
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      if (cmd.acc_clr) begin
        d_r <= '0;
      end else if (cmd.depth_step) begin
        d_r <= d_r + 1'b1;
      end
    end
  end

  // Running sum and product
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (add_done) begin
      acc_r <= add_res;
    end
    if (mul_done) prod_r <= mul_res;
  end

  bmm_fmul u_fmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mul_start),
    .op_a   (lrd_r),
    .op_b   (rrd_r),
    .done   (mul_done),
    .result (mul_res)
  );

  bmm_fadd u_fadd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.add_start),
    .op_a   (acc_r),
    .op_b   (prod_r),
    .done   (add_done),
    .result (add_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      oval_r  <= acc_r;
      orow_r  <= r_idx;
      ocol_r  <= c_idx;
      obat_r  <= BATCH_W'(bcnt_r);
      olast_r <= sts.elem_last;
    end
  end

  always_comb begin
    sts.depth_zero = (depth_eff == '0);
    sts.depth_last = (d_r == DW'(depth_eff - 1'b1));
    sts.elem_last  = (i_r == 3'(outer_n - 4'd1)) && (j_r == 3'(inner_n - 4'd1));
    sts.mul_done   = mul_done;
    sts.add_done   = add_done;
    sts.out_free   = !ov_r || out_ready;
  end

  assign out_valid         = ov_r;
  assign out_result_value  = oval_r;
  assign out_row           = orow_r;
  assign out_col           = ocol_r;
  assign out_batch_index   = obat_r;
  assign out_last_of_batch = olast_r;

  a_ptr_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && sts.elem_last) |=> (lptr_r == '0 && rptr_r == '0))
    else $error("load pointers not rewound after the last element");

  a_mul_latency: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> ##3 mul_done)
    else $error("product missing three cycles after start");

endmodule
